// ===== sv/alm_pkg.sv =====
`timescale 1ns / 1ps

package alm_pkg;

    // Default widths of the block.
    localparam int DEF_SAMPLE_BITS   = 24;
    localparam int DEF_COEFF_BITS    = 30;
    localparam int DEF_INTERVAL_BITS = 16;

    // Configuration channel.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MS_COEFF  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL  = 3'd4;

    // Meter modes.
    localparam int MODE_BITS = 3;
    typedef logic [MODE_BITS-1:0] t_mode;
    localparam t_mode MODE_VU       = 3'd0;
    localparam t_mode MODE_PPM      = 3'd1;
    localparam t_mode MODE_PEAK     = 3'd2;
    localparam t_mode MODE_HEADROOM = 3'd3;
    localparam t_mode MODE_FAST_DC  = 3'd4;
    localparam t_mode MODE_AVG_DC   = 3'd5;
    localparam t_mode MODE_RMS      = 3'd6;
    localparam t_mode MODE_CLIP     = 3'd7;

    // Reset values of the registers.
    localparam logic [31:0] RST_ATTACK   = 32'd0;
    localparam logic [31:0] RST_RELEASE  = 32'd1072996644;
    localparam logic [31:0] RST_MS_COEFF = 32'd1059772443;
    localparam logic [31:0] RST_INTERVAL = 32'd4785;

    // Shared multiplier and arithmetic constants.
    localparam int MUL_BITS   = 32;
    localparam int MAG_BITS   = 64;
    localparam int LOG_FRAC   = 24;
    localparam int READ_BITS  = 32;
    localparam int DB_RSH     = 36;
    localparam logic [MUL_BITS-1:0] DB_PER_OCTAVE_Q28 = 32'd1616142483;
    localparam logic signed [READ_BITS-1:0] DB_FLOOR  = -32'sd10485760;
    localparam logic signed [READ_BITS-1:0] DB_VU_OFS = 32'sd196608;

endpackage

// ===== sv/alm_ifs.sv =====
`timescale 1ns / 1ps

interface alm_in_if #(
    parameter int SAMPLE_BITS = alm_pkg::DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface alm_out_if ();
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   reading;
    logic                 in_db;

    modport source (output valid, output reading, output in_db, input ready);
    modport sink   (input valid, input reading, input in_db, output ready);
endinterface

interface alm_cfg_if ();
    logic                                   valid;
    logic                                   ready;
    logic [alm_pkg::CFG_IDX_BITS-1:0]       index;
    logic [alm_pkg::CFG_DATA_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/alm_regs.sv =====
`timescale 1ns / 1ps

module alm_regs #(
    parameter int COEFF_BITS    = alm_pkg::DEF_COEFF_BITS,
    parameter int INTERVAL_BITS = alm_pkg::DEF_INTERVAL_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    alm_cfg_if.sink                  i_cfg,
    output alm_pkg::t_mode           o_mode,
    output logic [COEFF_BITS-1:0]    o_attack,
    output logic [COEFF_BITS-1:0]    o_release,
    output logic [COEFF_BITS-1:0]    o_ms_coeff,
    output logic [INTERVAL_BITS-1:0] o_interval
);
    import alm_pkg::*;

    t_mode                  r_mode;
    logic [COEFF_BITS-1:0]  r_attack;
    logic [COEFF_BITS-1:0]  r_release;
    logic [COEFF_BITS-1:0]  r_ms_coeff;
    logic [INTERVAL_BITS-1:0] r_interval;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_PEAK;
            r_attack   <= RST_ATTACK[COEFF_BITS-1:0];
            r_release  <= RST_RELEASE[COEFF_BITS-1:0];
            r_ms_coeff <= RST_MS_COEFF[COEFF_BITS-1:0];
            r_interval <= RST_INTERVAL[INTERVAL_BITS-1:0];
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODE:     r_mode     <= i_cfg.data[MODE_BITS-1:0];
                REG_ATTACK:   r_attack   <= i_cfg.data[COEFF_BITS-1:0];
                REG_RELEASE:  r_release  <= i_cfg.data[COEFF_BITS-1:0];
                REG_MS_COEFF: r_ms_coeff <= i_cfg.data[COEFF_BITS-1:0];
                REG_INTERVAL: r_interval <= i_cfg.data[INTERVAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_mode     = r_mode;
    assign o_attack   = r_attack;
    assign o_release  = r_release;
    assign o_ms_coeff = r_ms_coeff;
    assign o_interval = r_interval;

endmodule

// ===== sv/alm_mul.sv =====
`timescale 1ns / 1ps

module alm_mul (
    input  logic                         i_clk,
    input  logic [alm_pkg::MUL_BITS-1:0]   i_a,
    input  logic [alm_pkg::MUL_BITS-1:0]   i_b,
    output logic [2*alm_pkg::MUL_BITS-1:0] o_prod
);
    import alm_pkg::*;

    logic [2*MUL_BITS-1:0] r_prod;

    // The product is registered; it is valid in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/alm_sqrt.sv =====
`timescale 1ns / 1ps

module alm_sqrt #(
    parameter int SAMPLE_BITS = alm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [2*SAMPLE_BITS-1:0]   i_value,
    output logic                       o_done,
    output logic [SAMPLE_BITS-1:0]     o_root
);
    localparam int CW = $clog2(SAMPLE_BITS + 1);

    logic                     r_busy;
    logic [CW-1:0]            r_cnt;
    logic [2*SAMPLE_BITS-1:0] r_val;
    logic [SAMPLE_BITS+1:0]   r_rem;
    logic [SAMPLE_BITS-1:0]   r_root;
    logic                     r_done;

    logic [SAMPLE_BITS+1:0]   n_rem;
    logic [SAMPLE_BITS+1:0]   trial;

    // One result bit per cycle: bring down two bits, try root*4+1.
    always_comb begin
        n_rem = {r_rem[SAMPLE_BITS-1:0], r_val[2*SAMPLE_BITS-1 -: 2]};
        trial = {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val <= r_val << 2;
                if (n_rem >= trial) begin
                    r_rem  <= n_rem - trial;
                    r_root <= {r_root[SAMPLE_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= n_rem;
                    r_root <= {r_root[SAMPLE_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(SAMPLE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== sv/audio_level_meter.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Payload                     Role
// i_in     sink       sample                      one audio sample per item
// o_res    source     reading, in_db              at most one meter reading per item
// i_cfg    sink       index, data                 register writes, always ready
//
// An accepted item runs the envelope smoother in peak, headroom and average DC modes,
// goes straight to the interval count in fast DC and clip detect, and in VU, PPM and
// RMS first squares the sample, smooths the mean square and takes its bit-serial root.
// A dB reading then normalizes the level, squares the mantissa once per log fraction bit
// on the one shared multiplier and scales the log into the output; linear ones skip this.
// i_in is not ready while an item is in work. A reading waits in the output
// register; the next item is taken while it waits, and only a second reading
// stalls until the first has been taken. Reset is synchronous and clears state.

module audio_level_meter #(
    parameter int SAMPLE_BITS   = alm_pkg::DEF_SAMPLE_BITS,
    parameter int COEFF_BITS    = alm_pkg::DEF_COEFF_BITS,
    parameter int INTERVAL_BITS = alm_pkg::DEF_INTERVAL_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alm_in_if.sink      i_in,
    alm_out_if.source   o_res,
    alm_cfg_if.sink     i_cfg
);
    import alm_pkg::*;

    localparam int FRAC     = SAMPLE_BITS - 1;
    localparam int ENV      = SAMPLE_BITS + 2;
    localparam int MS       = 2 * SAMPLE_BITS;
    localparam int W        = MAG_BITS + 2;
    localparam int LIN_RSH  = (FRAC > 16) ? FRAC - 16 : 0;
    localparam int LIN_LSH  = (FRAC < 16) ? 16 - FRAC : 0;
    localparam logic [MAG_BITS-1:0] LIN_HALF = (64'd1 << LIN_RSH) >> 1;

    // Sequencer states.
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SQ       = 5'd1;
    localparam logic [4:0] S_CM0      = 5'd2;
    localparam logic [4:0] S_CM1      = 5'd3;
    localparam logic [4:0] S_CM2      = 5'd4;
    localparam logic [4:0] S_MS_DONE  = 5'd5;
    localparam logic [4:0] S_SQRT     = 5'd6;
    localparam logic [4:0] S_BAL      = 5'd7;
    localparam logic [4:0] S_BAL_DONE = 5'd8;
    localparam logic [4:0] S_INTV     = 5'd9;
    localparam logic [4:0] S_LZ       = 5'd10;
    localparam logic [4:0] S_LOG_MUL  = 5'd11;
    localparam logic [4:0] S_LOG_ACC  = 5'd12;
    localparam logic [4:0] S_DB_MUL   = 5'd13;
    localparam logic [4:0] S_DB_WAIT  = 5'd14;
    localparam logic [4:0] S_EMIT     = 5'd15;

    // Configuration.
    t_mode                    cfg_mode;
    logic [COEFF_BITS-1:0]    cfg_attack;
    logic [COEFF_BITS-1:0]    cfg_release;
    logic [COEFF_BITS-1:0]    cfg_ms_coeff;
    logic [INTERVAL_BITS-1:0] cfg_interval;

    // Meter state.
    logic [4:0]               r_state;
    logic [4:0]               r_ret;
    logic signed [ENV-1:0]    r_env;
    logic [MS-1:0]            r_ms;
    logic signed [ENV-1:0]    r_last;
    logic                     r_has;
    logic [INTERVAL_BITS-1:0] r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_latest;
    logic [MS-1:0]            r_sq;
    logic signed [ENV-1:0]    r_level;

    // Coefficient product in progress.
    logic [MAG_BITS-1:0]      r_cm_mag;
    logic                     r_cm_neg;
    logic [COEFF_BITS-1:0]    r_cm_c;
    logic [MAG_BITS-1:0]      r_cm_acc;

    // Log2 in progress.
    logic [ENV-2:0]           r_w;
    logic signed [7:0]        r_n;
    logic [MUL_BITS-1:0]      r_mx;
    logic [LOG_FRAC-1:0]      r_frac;
    logic [4:0]               r_it;
    logic                     r_l2_neg;
    logic signed [READ_BITS-1:0] r_rd;

    // Output register.
    logic                     r_out_valid;
    logic signed [READ_BITS-1:0] r_out_reading;
    logic                     r_out_in_db;

    // Shared units.
    logic [MUL_BITS-1:0]      mul_a;
    logic [MUL_BITS-1:0]      mul_b;
    logic [2*MUL_BITS-1:0]    r_prod;
    logic                     sq_done;
    logic [SAMPLE_BITS-1:0]   sq_root;

    // Datapath values.
    logic [SAMPLE_BITS-1:0]   abs_in;
    logic signed [MS:0]       ms_diff;
    logic [MS:0]              ms_diff_mag;
    logic signed [ENV:0]      bal_diff;
    logic [ENV:0]             bal_diff_mag;
    logic signed [MAG_BITS:0] cm_val;
    logic signed [W-1:0]      ms_sum;
    logic [MS-1:0]            n_ms;
    logic signed [W-1:0]      bal_sum;
    logic signed [ENV-1:0]    n_env;
    logic signed [ENV-1:0]    lvl;
    logic signed [ENV+3:0]    lin10;
    logic [ENV+3:0]           lin_mag;
    logic [MAG_BITS-1:0]      lin_round;
    logic signed [READ_BITS-1:0] lin_rd;
    logic [ENV+30:0]          lz_wide;
    logic [MUL_BITS:0]        log_t;
    logic signed [31:0]       l2;
    logic [31:0]              l2_mag;
    logic [READ_BITS-1:0]     db_mag;
    logic signed [READ_BITS-1:0] db_final;
    logic                     full_scale;
    logic                     emit_load;

    alm_regs #(
        .COEFF_BITS    (COEFF_BITS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .o_mode     (cfg_mode),
        .o_attack   (cfg_attack),
        .o_release  (cfg_release),
        .o_ms_coeff (cfg_ms_coeff),
        .o_interval (cfg_interval)
    );

    alm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (r_prod)
    );

    alm_sqrt #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MS_DONE),
        .i_value (n_ms),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        abs_in = i_in.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_in.sample)
                                            : SAMPLE_BITS'(i_in.sample);
        full_scale = (i_in.sample == {1'b1, {(SAMPLE_BITS-1){1'b0}}})
                  || (i_in.sample == {1'b0, {(SAMPLE_BITS-1){1'b1}}});

        // Mean square minus the new square, for the one-pole smoother.
        ms_diff     = $signed({1'b0, r_ms}) - $signed({1'b0, r_prod[MS-1:0]});
        ms_diff_mag = ms_diff[MS] ? (MS+1)'(-ms_diff) : (MS+1)'(ms_diff);

        bal_diff     = (ENV+1)'(r_env) - (ENV+1)'(r_level);
        bal_diff_mag = bal_diff[ENV] ? (ENV+1)'(-bal_diff) : (ENV+1)'(bal_diff);

        cm_val = r_cm_neg ? -$signed({1'b0, r_cm_acc}) : $signed({1'b0, r_cm_acc});

        // New mean square, clamped to its unsigned range.
        ms_sum = $signed(W'({1'b0, r_sq})) + W'(cm_val);
        if (ms_sum < 0) begin
            n_ms = '0;
        end else if (ms_sum > $signed(W'({MS{1'b1}}))) begin
            n_ms = '1;
        end else begin
            n_ms = ms_sum[MS-1:0];
        end

        // New envelope, saturated to its signed range.
        bal_sum = W'(r_level) + W'(cm_val);
        if (bal_sum > $signed(W'({(ENV-1){1'b1}}))) begin
            n_env = {1'b0, {(ENV-1){1'b1}}};
        end else if (bal_sum < -$signed(W'({(ENV-1){1'b1}})) - W'(1)) begin
            n_env = {1'b1, {(ENV-1){1'b0}}};
        end else begin
            n_env = bal_sum[ENV-1:0];
        end

        lvl = (cfg_mode == MODE_FAST_DC) ? ENV'(r_latest) : r_env;

        // Linear reading: level times ten, rescaled to Q15.16 with rounding.
        lin10     = ((ENV+4)'(lvl) <<< 3) + ((ENV+4)'(lvl) <<< 1);
        lin_mag   = lin10[ENV+3] ? (ENV+4)'(-lin10) : (ENV+4)'(lin10);
        lin_round = ((MAG_BITS'(lin_mag) << LIN_LSH) + LIN_HALF) >> LIN_RSH;
        lin_rd    = lin10[ENV+3] ? -$signed(lin_round[READ_BITS-1:0])
                                 : $signed(lin_round[READ_BITS-1:0]);

        lz_wide = {r_w, {MUL_BITS{1'b0}}};
        log_t   = r_prod[2*MUL_BITS-1:MUL_BITS-1];

        l2     = ((32'(r_n) - 32'(FRAC)) <<< LOG_FRAC) + 32'(r_frac);
        l2_mag = l2[31] ? 32'(-l2) : 32'(l2);

        db_mag = READ_BITS'((r_prod + (64'd1 << (DB_RSH - 1))) >> DB_RSH);

        if (cfg_mode == MODE_VU || cfg_mode == MODE_PPM) begin
            db_final = r_rd + DB_VU_OFS;
        end else if (cfg_mode == MODE_HEADROOM) begin
            db_final = -r_rd;
        end else begin
            db_final = r_rd;
        end

        // The shared multiplier takes its operands from the current step.
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_IDLE: begin
                mul_a = MUL_BITS'(abs_in);
                mul_b = MUL_BITS'(abs_in);
            end
            S_CM0: begin
                mul_a = r_cm_mag[MUL_BITS-1:0];
                mul_b = MUL_BITS'(r_cm_c);
            end
            S_CM1: begin
                mul_a = r_cm_mag[MAG_BITS-1:MUL_BITS];
                mul_b = MUL_BITS'(r_cm_c);
            end
            S_LOG_MUL: begin
                mul_a = r_mx;
                mul_b = r_mx;
            end
            S_DB_MUL: begin
                mul_a = l2_mag;
                mul_b = DB_PER_OCTAVE_Q28;
            end
            default: ;
        endcase

        emit_load = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_env    <= '0;
            r_ms     <= '0;
            r_last   <= '0;
            r_has    <= 1'b0;
            r_cnt    <= '0;
            r_latest <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_latest <= i_in.sample;
                        case (cfg_mode) inside
                            MODE_VU, MODE_PPM, MODE_RMS: begin
                                r_state <= S_SQ;
                            end
                            MODE_PEAK, MODE_HEADROOM: begin
                                r_level <= ENV'(abs_in);
                                r_state <= S_BAL;
                            end
                            MODE_AVG_DC: begin
                                r_level <= ENV'(i_in.sample);
                                r_state <= S_BAL;
                            end
                            MODE_CLIP: begin
                                if (full_scale) begin
                                    r_env <= ENV'(1) <<< FRAC;
                                end
                                r_state <= S_INTV;
                            end
                            default: r_state <= S_INTV;
                        endcase
                    end
                end
                S_SQ: begin
                    r_sq     <= r_prod[MS-1:0];
                    r_cm_mag <= MAG_BITS'(ms_diff_mag[MS-1:0]);
                    r_cm_neg <= ms_diff[MS];
                    r_cm_c   <= cfg_ms_coeff;
                    r_ret    <= S_MS_DONE;
                    r_state  <= S_CM0;
                end
                S_CM0: begin
                    r_state <= S_CM1;
                end
                S_CM1: begin
                    r_cm_acc <= MAG_BITS'(r_prod >> COEFF_BITS);
                    r_state  <= S_CM2;
                end
                S_CM2: begin
                    r_cm_acc <= r_cm_acc + MAG_BITS'(r_prod << (MUL_BITS - COEFF_BITS));
                    r_state  <= r_ret;
                end
                S_MS_DONE: begin
                    r_ms    <= n_ms;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_level <= ENV'(sq_root);
                        r_state <= S_BAL;
                    end
                end
                S_BAL: begin
                    r_cm_mag <= MAG_BITS'(bal_diff_mag[ENV-1:0]);
                    r_cm_neg <= bal_diff[ENV];
                    r_cm_c   <= (cfg_mode != MODE_AVG_DC && bal_diff[ENV]) ? cfg_attack
                                                                           : cfg_release;
                    r_ret    <= S_BAL_DONE;
                    r_state  <= S_CM0;
                end
                S_BAL_DONE: begin
                    r_env   <= n_env;
                    r_state <= S_INTV;
                end
                S_INTV: begin
                    if ((INTERVAL_BITS+1)'(r_cnt) + 1'b1 < (INTERVAL_BITS+1)'(cfg_interval)) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= '0;
                        if (!r_has || lvl != r_last) begin
                            r_has  <= 1'b1;
                            r_last <= lvl;
                            if (cfg_mode < MODE_FAST_DC) begin
                                if (lvl <= 0) begin
                                    r_rd    <= DB_FLOOR;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_w     <= lvl[ENV-2:0];
                                    r_n     <= 8'(ENV - 2);
                                    r_state <= S_LZ;
                                end
                            end else begin
                                r_rd    <= lin_rd;
                                r_state <= S_EMIT;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                        // Clip detect starts over at every interval end.
                        if (cfg_mode == MODE_CLIP) begin
                            r_env <= '0;
                        end
                    end
                end
                S_LZ: begin
                    // Normalize one bit a cycle until the top bit is set.
                    if (r_w[ENV-2]) begin
                        r_mx    <= lz_wide[ENV+30 -: MUL_BITS];
                        r_frac  <= '0;
                        r_it    <= '0;
                        r_state <= S_LOG_MUL;
                    end else begin
                        r_w <= r_w << 1;
                        r_n <= r_n - 8'sd1;
                    end
                end
                S_LOG_MUL: begin
                    r_state <= S_LOG_ACC;
                end
                S_LOG_ACC: begin
                    // Squaring the mantissa doubles the log; an overflow is one bit.
                    r_frac <= {r_frac[LOG_FRAC-2:0], log_t[MUL_BITS]};
                    r_mx   <= log_t[MUL_BITS] ? log_t[MUL_BITS:1] : log_t[MUL_BITS-1:0];
                    r_it   <= r_it + 1'b1;
                    r_state <= (r_it == 5'(LOG_FRAC - 1)) ? S_DB_MUL : S_LOG_MUL;
                end
                S_DB_MUL: begin
                    r_l2_neg <= l2[31];
                    r_state  <= S_DB_WAIT;
                end
                S_DB_WAIT: begin
                    r_rd    <= r_l2_neg ? -$signed(db_mag) : $signed(db_mag);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_out_reading <= (cfg_mode < MODE_FAST_DC) ? db_final : r_rd;
            r_out_in_db   <= (cfg_mode < MODE_FAST_DC);
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.reading = r_out_reading;
    assign o_res.in_db   = r_out_in_db;

    // An accepted item always puts the sequencer to work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("item accepted but sequencer stayed idle");

    // A reading ready with a free output register is loaded at once.
    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_out_valid) |=> r_out_valid)
        else $error("reading not loaded into a free output register");

    // Once a reading is started, only reset clears the flag.
    a_has_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_has))
        else $error("reported flag dropped without reset");

    // The root unit finishes only while the sequencer waits for it.
    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_SQRT))
        else $error("square root finished outside its wait state");

endmodule

// ===== verif/audio_level_meter_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the audio level meter.
// Samples go in through the input channel. Results are checked against a
// behavioral meter model that runs inside this module.
module audio_level_meter_tb;
    import alm_pkg::*;

    localparam int  CYCLE_LIMIT  = 1_000_000;
    // Items that end a reading interval are in work the longest.
    localparam int  SETTLE_CYCLES = 200;
    localparam longint ENV_MAX   = (64'sd1 <<< 25) - 1;
    localparam longint ENV_MIN   = -(64'sd1 <<< 25);
    localparam longint MS_TOP    = (64'sd1 <<< 48) - 1;
    localparam longint FULL      = 64'sd1 <<< 23;
    localparam logic [31:0] COEFF_MAX = 32'd1073741823;
    localparam logic signed [23:0] S_MIN = -24'sd8388608;
    localparam logic signed [23:0] S_MAX = 24'sd8388607;

    typedef struct {
        logic                   is_cfg;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [31:0]            val;
        logic signed [23:0]     smp;
        logic                   typed;
        logic signed [31:0]     rd;
        logic                   db;
    } t_stim_row;

    typedef struct {
        logic signed [31:0] rd;
        logic               db;
    } t_reading;

    logic i_clk;
    logic i_rst_n;

    alm_in_if  in_if ();
    alm_out_if res_if ();
    alm_cfg_if cfg_if ();

    audio_level_meter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Copy of the meter's configuration and state, kept by the predictor.
    t_mode           m_mode;
    longint unsigned m_atk_coeff, m_rel_coeff, m_ms_coeff, m_interval;
    longint          m_env, m_last_level, m_latest;
    longint unsigned m_mean_sq, m_count;
    bit              m_reported;

    t_reading  pending_readings[$];
    t_stim_row dir_rows[$];
    int        err_cnt;
    int        cycle_cnt = 0;
    int        items_sent;
    int        readings_seen;
    int        snd_idle_pct;
    int        rcv_idle_pct;
    logic signed [23:0] prev_sample;

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        err_cnt++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Signed operand times a Q0.30 factor, truncated toward zero.
    function automatic longint scale_q30(input longint d, input longint unsigned c);
        longint unsigned mag;
        logic [127:0]    p;
        mag = (d < 0) ? -d : d;
        p = {64'd0, mag} * {64'd0, c};
        p = p >> 30;
        return (d < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint clamp_env(input longint v);
        return (v > ENV_MAX) ? ENV_MAX : ((v < ENV_MIN) ? ENV_MIN : v);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_away(input longint v, input int sh);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // 20*log10(level / 2^23) in Q15.16 for a positive level.
    function automatic longint level_to_db(input longint lvl);
        longint unsigned v, x, frac;
        longint          l2;
        int              n;
        v = lvl;
        n = 0;
        frac = 0;
        while (n < 63 && (v >> (n + 1)) != 0) n++;
        x = (n <= 31) ? (v << (31 - n)) : (v >> (n - 31));
        for (int i = 0; i < LOG_FRAC; i++) begin
            x = (x * x) >> 31;
            frac <<= 1;
            if (x >= (64'd1 << 32)) begin
                frac |= 1;
                x >>= 1;
            end
        end
        l2 = longint'(n - 23) * (64'sd1 <<< LOG_FRAC) + longint'(frac);
        return round_away(l2 * longint'(DB_PER_OCTAVE_Q28), DB_RSH);
    endfunction

    function automatic void follow_level(input longint lvl);
        longint diff;
        diff = m_env - lvl;
        m_env = clamp_env(lvl + scale_q30(diff, (diff < 0) ? m_atk_coeff : m_rel_coeff));
    endfunction

    function automatic void meter_reset();
        m_mode = MODE_PEAK;
        m_atk_coeff = RST_ATTACK;
        m_rel_coeff = RST_RELEASE;
        m_ms_coeff = RST_MS_COEFF;
        m_interval = RST_INTERVAL;
        m_env = 0;
        m_mean_sq = 0;
        m_last_level = 0;
        m_reported = 0;
        m_count = 0;
        m_latest = 0;
    endfunction

    function automatic void meter_write(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [31:0] val);
        case (idx)
            REG_MODE:     m_mode = val[MODE_BITS-1:0];
            REG_ATTACK:   m_atk_coeff = val[29:0];
            REG_RELEASE:  m_rel_coeff = val[29:0];
            REG_MS_COEFF: m_ms_coeff = val[29:0];
            REG_INTERVAL: m_interval = val[15:0];
            default: ;
        endcase
    endfunction

    // Advances the meter by one sample; returns 1 when a reading is due.
    function automatic bit meter_step(input logic signed [23:0] s, output t_reading r);
        longint          x, lvl, rd, d, ms;
        longint unsigned sq;
        x = s;
        m_latest = x;
        case (m_mode)
            MODE_VU, MODE_PPM, MODE_RMS: begin
                sq = (x < 0 ? -x : x) * (x < 0 ? -x : x);
                d = longint'(m_mean_sq) - longint'(sq);
                ms = longint'(sq) + scale_q30(d, m_ms_coeff);
                m_mean_sq = (ms < 0) ? 0 : ((ms > MS_TOP) ? MS_TOP : ms);
                follow_level(floor_sqrt(m_mean_sq));
            end
            MODE_PEAK, MODE_HEADROOM: follow_level(x < 0 ? -x : x);
            MODE_AVG_DC: m_env = clamp_env(x + scale_q30(m_env - x, m_rel_coeff));
            MODE_CLIP: if (x == -FULL || x == FULL - 1) m_env = FULL;
            default: ;
        endcase
        // An interval of zero behaves as one.
        if (m_count + 1 < m_interval) begin
            m_count = (m_count + 1) & 16'hFFFF;
            return 0;
        end
        m_count = 0;
        lvl = (m_mode == MODE_FAST_DC) ? m_latest : m_env;
        meter_step = 0;
        if (!m_reported || lvl != m_last_level) begin
            m_reported = 1;
            m_last_level = lvl;
            if (m_mode < MODE_FAST_DC) begin
                rd = (lvl <= 0) ? longint'(DB_FLOOR) : level_to_db(lvl);
                if (m_mode <= MODE_PPM) rd += longint'(DB_VU_OFS);
                if (m_mode == MODE_HEADROOM) rd = -rd;
            end else begin
                rd = round_away(lvl * 10, 7);
            end
            r.rd = rd[31:0];
            r.db = (m_mode < MODE_FAST_DC);
            meter_step = 1;
        end
        // Clip detect starts every interval from a clear envelope.
        if (m_mode == MODE_CLIP) m_env = 0;
    endfunction

    // Sends one sample, idling at random first; valid stays high afterwards.
    task automatic send_sample(input logic signed [23:0] s, input bit typed,
                               input logic signed [31:0] t_rd, input logic t_db);
        t_reading r;
        bit       due;
        while ($urandom_range(99) < snd_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= s;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
        prev_sample = s;
        due = meter_step(s, r);
        if (typed) begin
            if (!due) report_error($sformatf("model gives no reading for sample %0d", s));
            r.rd = t_rd;
            r.db = t_db;
            due = 1;
        end
        if (due) pending_readings.push_back(r);
    endtask

    // Waits until the meter has nothing in work.
    task automatic wait_quiet();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        meter_write(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [31:0] val);
        t_stim_row row;
        row = '{1'b1, idx, val, '0, 1'b0, '0, 1'b0};
        return row;
    endfunction

    function automatic t_stim_row smp_row(input logic signed [23:0] s);
        t_stim_row row;
        row = '{1'b0, '0, '0, s, 1'b0, '0, 1'b0};
        return row;
    endfunction

    function automatic t_stim_row known_row(input logic signed [23:0] s,
                                            input logic signed [31:0] rd, input logic db);
        t_stim_row row;
        row = '{1'b0, '0, '0, s, 1'b1, rd, db};
        return row;
    endfunction

    function automatic logic [31:0] pick_coeff();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return COEFF_MAX;
            2: return COEFF_MAX - $urandom_range(1 << 20);
            default: return $urandom_range(COEFF_MAX);
        endcase
    endfunction

    function automatic logic signed [23:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return S_MIN;
        if (roll < 16) return S_MAX;
        if (roll < 30) return $signed(24'($urandom_range(510))) - 24'sd255;
        if (roll < 42) return prev_sample;
        return 24'($urandom);
    endfunction

    // Result side: random stalls, and each reading is checked against the oldest
    // expectation in the queue.
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
            if (res_if.valid && res_if.ready) begin
                readings_seen++;
                if (pending_readings.size() == 0) begin
                    report_error($sformatf("unexpected reading %0d", res_if.reading));
                end else begin
                    want = pending_readings.pop_front();
                    if (res_if.reading !== want.rd)
                        report_error($sformatf("reading %0d, expected %0d",
                                               res_if.reading, want.rd));
                    if (res_if.in_db !== want.db)
                        report_error($sformatf("in_db %0b, expected %0b",
                                               res_if.in_db, want.db));
                end
            end
        end
    end

    // Hard stop in case the meter hangs.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings outstanding",
                     cycle_cnt, pending_readings.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        err_cnt = 0;
        items_sent = 0;
        readings_seen = 0;
        snd_idle_pct = 31;
        rcv_idle_pct = 72;
        prev_sample = '0;
        meter_reset();
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.sample = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;

        // Directed rows. Values typed in are the obvious ones: silence at the
        // floor, full scale at 0 dB, clip and fast DC at full scale.
        dir_rows.push_back(cfg_row(REG_INTERVAL, 32'd0));
        dir_rows.push_back(known_row(24'sd0, DB_FLOOR, 1'b1));
        dir_rows.push_back(known_row(S_MIN, 32'sd0, 1'b1));
        dir_rows.push_back(smp_row(S_MAX));
        dir_rows.push_back(smp_row(24'sd1));
        dir_rows.push_back(cfg_row(REG_RELEASE, 32'd0));
        dir_rows.push_back(smp_row(24'sd1));
        dir_rows.push_back(cfg_row(REG_MODE, 32'(MODE_HEADROOM)));
        dir_rows.push_back(known_row(24'sd0, -DB_FLOOR, 1'b1));
        dir_rows.push_back(cfg_row(REG_MODE, 32'(MODE_VU)));
        dir_rows.push_back(cfg_row(REG_MS_COEFF, 32'd0));
        dir_rows.push_back(known_row(S_MIN, DB_VU_OFS, 1'b1));
        dir_rows.push_back(cfg_row(REG_MODE, 32'(MODE_PPM)));
        dir_rows.push_back(smp_row(S_MAX));
        dir_rows.push_back(cfg_row(REG_MODE, 32'(MODE_RMS)));
        dir_rows.push_back(cfg_row(REG_ATTACK, COEFF_MAX));
        dir_rows.push_back(smp_row(24'sd4096));
        dir_rows.push_back(cfg_row(REG_MODE, 32'(MODE_CLIP)));
        dir_rows.push_back(known_row(S_MAX, 32'sd655360, 1'b0));
        dir_rows.push_back(smp_row(S_MIN));
        dir_rows.push_back(known_row(24'sd0, 32'sd0, 1'b0));
        dir_rows.push_back(cfg_row(REG_MODE, 32'(MODE_AVG_DC)));
        dir_rows.push_back(cfg_row(REG_RELEASE, COEFF_MAX));
        dir_rows.push_back(smp_row(S_MIN));
        dir_rows.push_back(cfg_row(REG_MODE, 32'(MODE_FAST_DC)));
        dir_rows.push_back(known_row(S_MIN, -32'sd655360, 1'b0));
        dir_rows.push_back(smp_row(S_MIN));
        dir_rows.push_back(smp_row(S_MAX));
        dir_rows.push_back(cfg_row(REG_INTERVAL, 32'd65535));
        dir_rows.push_back(smp_row(24'sd77));
        dir_rows.push_back(smp_row(-24'sd5));
        dir_rows.push_back(smp_row(24'sd1234));
        dir_rows.push_back(cfg_row(REG_INTERVAL, 32'd3));
        dir_rows.push_back(smp_row(-24'sd99));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                wait_quiet();
                write_reg(row.idx, row.val);
            end else begin
                send_sample(row.smp, row.typed, row.rd, row.db);
            end
        end

        // Random part in three idling phases, each a series of fresh settings.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin snd_idle_pct = 31; rcv_idle_pct = 72; end
                1: begin snd_idle_pct = 72; rcv_idle_pct = 31; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            for (int blk = 0; blk < 15; blk++) begin
                wait_quiet();
                write_reg(REG_MODE, $urandom_range(7));
                write_reg(REG_ATTACK, pick_coeff());
                write_reg(REG_RELEASE, pick_coeff());
                write_reg(REG_MS_COEFF, pick_coeff());
                write_reg(REG_INTERVAL, ($urandom_range(9) == 0) ?
                                        $urandom_range(20) : $urandom_range(1, 4));
                for (int k = 0; k < 32; k++) send_sample(pick_sample(), 1'b0, '0, 1'b0);
            end
        end

        wait_quiet();
        $display("Sent %0d samples over all eight modes and several register settings.",
                 items_sent);
        $display("Checked %0d readings under three stall patterns.", readings_seen);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/alm_pkg.sv
sv/alm_ifs.sv
sv/alm_regs.sv
sv/alm_mul.sv
sv/alm_sqrt.sv
sv/audio_level_meter.sv
verif/audio_level_meter_tb.sv
